>>> hdl/ier_pkg.sv
// Shared types, constants and helper functions of the input event remapper.
`timescale 1ns / 1ps

package ier_pkg;

  // Number of rule registers on the configuration port and of rule slots checked.
  localparam int NumRuleRegs = 8;
  localparam int RuleSlots   = 8;
  localparam int RuleW       = 23;
  localparam int RegIdxW     = $clog2(NumRuleRegs);
  localparam int PaddrW      = RegIdxW + 2;
  localparam int PdataW      = 32;

  // Event types.
  localparam logic [4:0] TypeSyn = 5'd0;
  localparam logic [4:0] TypeKey = 5'd1;
  localparam logic [4:0] TypeRel = 5'd2;

  // Event codes with special handling.
  localparam logic [9:0] CodeReport   = 10'h000;
  localparam logic [9:0] CodeHwheel   = 10'h006;
  localparam logic [9:0] CodeWheel    = 10'h008;
  localparam logic [9:0] CodeWheelHr  = 10'h00B;
  localparam logic [9:0] CodeHwheelHr = 10'h00C;
  localparam logic [9:0] KeyLow       = 10'h100;
  localparam logic [9:0] KeyEnd       = 10'h2FF;
  localparam logic [9:0] RelEnd       = 10'h00F;

  // Rule direction codes; the fourth code never matches.
  localparam logic [1:0] DirAny = 2'd0;
  localparam logic [1:0] DirPos = 2'd1;
  localparam logic [1:0] DirNeg = 2'd2;

  typedef struct packed {
    logic       enable;
    logic [9:0] dst;
    logic [1:0] dir;
    logic [9:0] src;
  } rule_t;

  typedef struct packed {
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
  } in_word_t;

  typedef struct packed {
    logic [4:0]         out_type;
    logic [9:0]         out_code;
    logic signed [31:0] out_value;
    logic               last;
  } out_word_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic               burst;
    logic [4:0]         ev_type;
    logic [9:0]         code;
    logic signed [31:0] value;
  } cmd_t;

  function automatic logic [4:0] implied_type(input logic [9:0] code);
    logic [4:0] t;
    if (code >= KeyLow && code < KeyEnd) begin
      t = TypeKey;
    end else if (code < RelEnd) begin
      t = TypeRel;
    end else begin
      t = TypeSyn;
    end
    return t;
  endfunction

  function automatic logic dir_ok(input logic [1:0] dir, input logic signed [31:0] value);
    logic ok;
    case (dir)
      DirAny:  ok = 1'b1;
      DirPos:  ok = !value[31] && (value != 32'sd0);
      DirNeg:  ok = value[31];
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hdl/ier_front.sv
// Front end: accepts input words, matches them against the rules and tracks wheel marks.
`timescale 1ns / 1ps

module ier_front (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  ier_pkg::rule_t [ier_pkg::NumRuleRegs-1:0]   rules_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  ier_pkg::in_word_t                           in_word_i,
  input  logic                                        q_full_i,
  output logic                                        push_o,
  output ier_pkg::cmd_t                               cmd_o
);

  logic           wheel_q, wheel_d;
  logic           hwheel_q, hwheel_d;
  logic           hit;
  ier_pkg::rule_t hit_rule;
  logic [4:0]     dst_type;
  logic           is_report;
  logic           drop;
  logic           accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_report  = (in_word_i.event_type == ier_pkg::TypeSyn) &&
                      (in_word_i.event_code == ier_pkg::CodeReport);

  // All rule compares run in parallel; the lowest matching slot wins.
  always_comb begin
    hit      = 1'b0;
    hit_rule = '0;
    for (int i = ier_pkg::RuleSlots - 1; i >= 0; i--) begin
      if (rules_i[i].enable &&
          rules_i[i].src == in_word_i.event_code &&
          ier_pkg::implied_type(rules_i[i].src) != ier_pkg::TypeSyn &&
          ier_pkg::implied_type(rules_i[i].src) == in_word_i.event_type &&
          ier_pkg::dir_ok(rules_i[i].dir, in_word_i.event_value)) begin
        hit      = 1'b1;
        hit_rule = rules_i[i];
      end
    end
  end

  assign dst_type = ier_pkg::implied_type(hit_rule.dst);

  always_comb begin
    cmd_o.burst   = 1'b0;
    cmd_o.ev_type = in_word_i.event_type;
    cmd_o.code    = in_word_i.event_code;
    cmd_o.value   = in_word_i.event_value;
    drop          = 1'b0;
    wheel_d       = wheel_q;
    hwheel_d      = hwheel_q;
    if (is_report) begin
      wheel_d  = 1'b0;
      hwheel_d = 1'b0;
    end else if (hit) begin
      cmd_o.code = hit_rule.dst;
      if (in_word_i.event_type == ier_pkg::TypeRel && dst_type == ier_pkg::TypeKey) begin
        cmd_o.burst = 1'b1;
        if (in_word_i.event_code == ier_pkg::CodeWheel) begin
          wheel_d = 1'b1;
        end else if (in_word_i.event_code == ier_pkg::CodeHwheel) begin
          hwheel_d = 1'b1;
        end
      end else begin
        cmd_o.ev_type = dst_type;
      end
    end else if (in_word_i.event_type == ier_pkg::TypeRel &&
                 ((in_word_i.event_code == ier_pkg::CodeWheelHr && wheel_q) ||
                  (in_word_i.event_code == ier_pkg::CodeHwheelHr && hwheel_q))) begin
      drop = 1'b1;
    end
  end

  assign push_o = accept && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q  <= 1'b0;
      hwheel_q <= 1'b0;
    end else if (accept) begin
      wheel_q  <= wheel_d;
      hwheel_q <= hwheel_d;
    end
  end

endmodule

>>> hdl/ier_fifo.sv
// Two-entry queue of classified items between the front and the back.
`timescale 1ns / 1ps

module ier_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ier_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output ier_pkg::cmd_t pop_data_o,
  output logic          empty_o,
  output logic          full_o
);

  ier_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_pop;

  assign empty_o    = (count_q == 2'd0);
  assign full_o     = (count_q == 2'd2);
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && push_i |-> do_pop)
    else $error("queue written while full");

endmodule

>>> hdl/ier_back.sv
// Back end: expands queued items into output words behind an output register.
`timescale 1ns / 1ps

module ier_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ier_pkg::cmd_t      cmd_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ier_pkg::out_word_t out_word_o
);

  localparam logic [1:0] BeatReport1 = 2'd1;
  localparam logic [1:0] BeatRelease = 2'd2;
  localparam logic [1:0] BeatReport2 = 2'd3;

  ier_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               burst_q, burst_d;
  logic [1:0]         beat_q, beat_d;
  logic [9:0]         dst_q, dst_d;
  logic               load;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !burst_q && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    burst_d     = burst_q;
    beat_d      = beat_q;
    dst_d       = dst_q;
    if (load) begin
      if (burst_q) begin
        out_valid_d = 1'b1;
        beat_d      = beat_q + 2'd1;
        case (beat_q)
          BeatRelease: out_d = '{ier_pkg::TypeKey, dst_q, 32'sd0, 1'b0};
          BeatReport2: begin
            out_d   = '{ier_pkg::TypeSyn, ier_pkg::CodeReport, 32'sd0, 1'b1};
            burst_d = 1'b0;
          end
          default:     out_d = '{ier_pkg::TypeSyn, ier_pkg::CodeReport, 32'sd0, 1'b0};
        endcase
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        if (cmd_i.burst) begin
          out_d   = '{ier_pkg::TypeKey, cmd_i.code, 32'sd1, 1'b0};
          burst_d = 1'b1;
          beat_d  = BeatReport1;
          dst_d   = cmd_i.code;
        end else begin
          out_d = '{cmd_i.ev_type, cmd_i.code, cmd_i.value, 1'b1};
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    dst_q <= dst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q     <= 1'b0;
      beat_q      <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      burst_q     <= burst_d;
      beat_q      <= beat_d;
    end
  end

  // While a burst is in flight the previous beat sits in the output register.
  a_burst_has_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> out_valid_q && !out_q.last)
    else $error("burst active without a pending word");

  // A taken word that is not the last of its item is followed at once by the next beat.
  a_burst_gapless : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !out_q.last |=> out_valid_q)
    else $error("gap inside a burst");

  // No new item is taken from the queue while a burst is still being expanded.
  a_no_pop_in_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !pop_o)
    else $error("queue popped during a burst");

endmodule

>>> hdl/input_event_remapper.sv
// Top level of the input event remapper: rule registers, front end, queue and back end.
`timescale 1ns / 1ps

// The block takes input event words (type, code, signed value) on a valid/ready
// channel and returns output event words on a second valid/ready channel; each
// output word carries a last flag that marks the final word caused by an input.
// Eight remap rules are written through the APB-style port at byte addresses
// 0x00 to 0x1C and can be read back; they should only be changed while idle.
// The front end compares an event with all rules in the same cycle, updates the
// wheel marks and pushes a classified item into a two-entry queue; dropped
// hi-res events push nothing. The back end expands each item into one word, or
// four words for a relative event remapped to a key, into the output register.
// An accepted input is registered in a queue entry and then in the output register.
// While the receiver is ready, one word leaves per cycle, so single-word items
// sustain one input per cycle; during a four-word burst, input is still taken
// until the queue is full. When the receiver stalls, the output register holds
// its word, the queue fills and then input ready drops. Reset clears the rules,
// the wheel marks, the queue and the output valid flag.
module input_event_remapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ier_pkg::PaddrW-1:0]     paddr,
  input  logic [ier_pkg::PdataW-1:0]     pwdata,
  output logic [ier_pkg::PdataW-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ier_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ier_pkg::out_word_t             out_word_o
);

  ier_pkg::rule_t [ier_pkg::NumRuleRegs-1:0] rules_q;
  logic [ier_pkg::RegIdxW-1:0]               reg_idx;
  logic                                      reg_wr;
  logic                                      push, pop, q_empty, q_full;
  ier_pkg::cmd_t                             push_cmd, pop_cmd;

  // The register index is the word address; the port is always ready.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ier_pkg::PaddrW-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(ier_pkg::PdataW - ier_pkg::RuleW){1'b0}}, rules_q[reg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q <= '0;
    end else if (reg_wr) begin
      rules_q[reg_idx] <= pwdata[ier_pkg::RuleW-1:0];
    end
  end

  ier_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rules_i    (rules_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ier_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  ier_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
